>>> sv/polyphase_fir_resampler_top_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef POLYPHASE_FIR_RESAMPLER_TOP_MACROS_SVH
`define POLYPHASE_FIR_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFR_ASSERT_IMP(NAME, CK, RS, ANTE, CONS) \
  NAME: assert property (@(posedge CK) disable iff (RS) (ANTE) |-> (CONS)) \
    else $error("resampler assertion failed");

// Next-cycle implication, checked out of reset.
`define PFR_ASSERT_NEXT(NAME, CK, RS, ANTE, CONS) \
  NAME: assert property (@(posedge CK) disable iff (RS) (ANTE) |=> (CONS)) \
    else $error("resampler assertion failed");

`endif

>>> sv/pfr_pkg.sv
// Shared types, constants and rounding function of the polyphase resampler.
package pfr_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int MAX_TAPS     = 64;
  localparam int MAX_FACTOR   = 16;

  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int PHASE_W   = $clog2(MAX_FACTOR);
  localparam int FACTOR_W  = 5;
  localparam int NTAPS_W   = 7;
  localparam int CIDX_W    = 6;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH = PROD_W + TAP_AW;
  localparam int SHIFT_W   = ACC_WIDTH - COEF_WIDTH + 1;

  localparam logic [CFG_AW-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FACTOR     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_NUM_TAPS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEF_INDEX = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COEF_VALUE = 3'd4;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  // Write and read requests toward the tap and coefficient memories.
  typedef struct packed {
    logic              dl_we;
    logic [TAP_AW-1:0] dl_waddr;
    sample_t           dl_wdata;
    logic              cf_we;
    logic [TAP_AW-1:0] cf_waddr;
    coef_t             cf_wdata;
    logic              rd_en;
    logic [TAP_AW-1:0] dl_raddr;
    logic [TAP_AW-1:0] cf_raddr;
  } mem_req_t;

  localparam acc_t ROUND_BIAS = ACC_WIDTH'(1) <<< (COEF_WIDTH - 2);
  localparam logic signed [SHIFT_W-1:0] SAT_MAX = SHIFT_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [SHIFT_W-1:0] SAT_MIN = -SHIFT_W'(1 << (SAMPLE_WIDTH - 1));

  // Round half up from the product format to the sample format and saturate.
  function automatic sample_t round_sat(input acc_t a);
    acc_t                      r;
    logic signed [SHIFT_W-1:0] s;
    sample_t                   y;
    r = a + ROUND_BIAS;
    s = $signed(r[ACC_WIDTH-1:COEF_WIDTH-1]);
    if (s > SAT_MAX) begin
      y = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (s < SAT_MIN) begin
      y = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = s[SAMPLE_WIDTH-1:0];
    end
    return y;
  endfunction

endpackage

>>> sv/pfr_store.sv
// Tap history and coefficient memories with per-entry valid flags.
module pfr_store
  import pfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output sample_t  x,
  output coef_t    c,
  output logic     rd_valid
);

  sample_t             dl_mem [MAX_TAPS];
  coef_t               cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] dl_vld;
  logic [MAX_TAPS-1:0] cf_vld;
  sample_t             x_raw;
  coef_t               c_raw;
  logic                x_ok;
  logic                c_ok;

  always_ff @(posedge clk) begin
    if (req.dl_we) begin
      dl_mem[req.dl_waddr] <= req.dl_wdata;
    end
    if (req.cf_we) begin
      cf_mem[req.cf_waddr] <= req.cf_wdata;
    end
    if (req.rd_en) begin
      x_raw <= dl_mem[req.dl_raddr];
      c_raw <= cf_mem[req.cf_raddr];
      x_ok  <= dl_vld[req.dl_raddr];
      c_ok  <= cf_vld[req.cf_raddr];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      dl_vld   <= '0;
      cf_vld   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.dl_we) begin
        dl_vld[req.dl_waddr] <= 1'b1;
      end
      if (req.cf_we) begin
        cf_vld[req.cf_waddr] <= 1'b1;
      end
      rd_valid <= req.rd_en;
    end
  end

  assign x = x_ok ? x_raw : '0;
  assign c = c_ok ? c_raw : '0;

endmodule

>>> sv/pfr_mac.sv
// Registered multiply followed by accumulate, with rounded result.
module pfr_mac
  import pfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    clear,
  input  logic    in_valid,
  input  sample_t x,
  input  coef_t   c,
  output logic    busy,
  output sample_t result
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  acc_t                     acc;

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod <= x * c;
    end
    if (clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= in_valid;
    end
  end

  assign busy   = prod_v;
  assign result = round_sat(acc);

endmodule

>>> sv/polyphase_fir_resampler_top.sv
// Decimate: only a sample whose phase matches the target runs the filter and registers a result.
// Interpolate: each request is served by one shared multiply-accumulate that reads one tap
//   and one coefficient per cycle from the memories; a new request waits until it is done.
// Decimate accepts a sample that emits nothing without leaving idle; a factor or length write then
//   holds off requests while the decimation phase is recomputed.
// Reset (synchronous, active high) clears control registers and valid flags; no memory sweep.
module polyphase_fir_resampler_top
  import pfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // sample request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           sample,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output sample_t           out_sample,
  output logic              last,
  // register write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

`include "polyphase_fir_resampler_top_macros.svh"

  // Configuration registers.
  logic                mode;
  logic [FACTOR_W-1:0] factor;
  logic [NTAPS_W-1:0]  num_taps;
  logic [CIDX_W-1:0]   coef_index;

  logic [FACTOR_W-1:0] m_eff;
  logic [NTAPS_W-1:0]  n_eff;
  logic                cfg_we;

  // Decimation phase target: (M - N mod M) mod M by repeated subtraction.
  logic                tgt_start;
  logic                tgt_busy;
  logic [NTAPS_W-1:0]  rem;
  logic [PHASE_W-1:0]  tgt;

  // Sequencer.
  state_t              state, state_next;
  logic [TAP_AW-1:0]   head, head_next;
  logic [TAP_AW-1:0]   base, base_next;
  logic [PHASE_W-1:0]  phase_cnt, phase_next;
  logic [PHASE_W-1:0]  q, q_next;
  logic [NTAPS_W-1:0]  ca, ca_next;
  logic [TAP_AW-1:0]   d, d_next;
  logic [NTAPS_W-1:0]  step;
  logic                accept;
  logic                emit_last;
  logic                load_out;
  logic                mac_clear;
  logic                pipe_busy;

  logic                out_valid_next;
  sample_t             out_sample_next;
  logic                last_next;

  mem_req_t            req;
  sample_t             x_rd;
  coef_t               c_rd;
  logic                rd_valid;
  logic                mac_busy;
  sample_t             mac_result;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Clamp the factor to 1..MAX_FACTOR and the length to MAX_TAPS.
  always_comb begin
    if (factor == '0) begin
      m_eff = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      m_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      m_eff = factor;
    end
    n_eff = (num_taps > NTAPS_W'(MAX_TAPS)) ? NTAPS_W'(MAX_TAPS) : num_taps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      factor     <= FACTOR_W'(1);
      num_taps   <= NTAPS_W'(1);
      coef_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= cfg_data[0];
        REG_FACTOR:     factor     <= cfg_data[FACTOR_W-1:0];
        REG_NUM_TAPS:   num_taps   <= cfg_data[NTAPS_W-1:0];
        REG_COEF_INDEX: coef_index <= cfg_data[CIDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Start the target pass in the cycle after a factor or length write (the
  // clamped values are settled by then); a later write restarts the pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_start <= 1'b0;
      tgt_busy  <= 1'b0;
      tgt       <= '0;
    end else begin
      tgt_start <= cfg_we && (cfg_index == REG_FACTOR || cfg_index == REG_NUM_TAPS);
      if (tgt_start) begin
        rem      <= n_eff;
        tgt_busy <= 1'b1;
      end else if (tgt_busy) begin
        if (rem >= NTAPS_W'(m_eff)) begin
          rem <= rem - NTAPS_W'(m_eff);
        end else begin
          tgt_busy <= 1'b0;
          tgt      <= (rem == '0) ? '0 : PHASE_W'(m_eff - rem[FACTOR_W-1:0]);
        end
      end
    end
  end

  // Take one sample at a time; hold off while a target pass runs.
  assign in_stall  = (state != ST_IDLE) | tgt_busy | tgt_start;
  assign accept    = in_valid & ~in_stall;
  assign pipe_busy = rd_valid | mac_busy;
  assign step      = mode ? NTAPS_W'(m_eff) : NTAPS_W'(1);
  assign emit_last = ~mode | ({1'b0, q} == m_eff - FACTOR_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      phase_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      phase_cnt <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    base       <= base_next;
    q          <= q_next;
    ca         <= ca_next;
    d          <= d_next;
    out_sample <= out_sample_next;
    last       <= last_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    base_next       = base;
    phase_next      = phase_cnt;
    q_next          = q;
    ca_next         = ca;
    d_next          = d;
    out_valid_next  = out_valid & out_stall;
    out_sample_next = out_sample;
    last_next       = last;
    req             = '0;
    mac_clear       = 1'b0;
    load_out        = 1'b0;

    // Coefficient writes go straight into their memory.
    if (cfg_we && cfg_index == REG_COEF_VALUE) begin
      req.cf_we    = 1'b1;
      req.cf_waddr = coef_index[TAP_AW-1:0];
      req.cf_wdata = cfg_data[COEF_WIDTH-1:0];
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // Write the newest sample at the head of the circular history.
          req.dl_we    = 1'b1;
          req.dl_waddr = head;
          req.dl_wdata = sample;
          head_next    = head + TAP_AW'(1);
          base_next    = head;
          phase_next   = ({1'b0, phase_cnt} + FACTOR_W'(1) >= m_eff) ? '0
                                                                     : phase_cnt + PHASE_W'(1);
          q_next       = '0;
          ca_next      = '0;
          d_next       = '0;
          if (mode || phase_cnt == tgt) begin
            mac_clear  = 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        // Read one tap/coefficient pair per cycle until the index leaves the filter.
        if (ca < n_eff) begin
          req.rd_en    = 1'b1;
          req.dl_raddr = base - d;
          req.cf_raddr = ca[TAP_AW-1:0];
          ca_next      = ca + step;
          d_next       = d + TAP_AW'(1);
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Drain the multiply pipeline, then post the result once the output register is free.
        if (!pipe_busy && (!out_valid || !out_stall)) begin
          load_out        = 1'b1;
          out_valid_next  = 1'b1;
          out_sample_next = mac_result;
          last_next       = emit_last;
          if (emit_last) begin
            state_next = ST_IDLE;
          end else begin
            q_next     = q + PHASE_W'(1);
            ca_next    = NTAPS_W'(q) + NTAPS_W'(1);
            d_next     = '0;
            mac_clear  = 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  pfr_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .x        (x_rd),
    .c        (c_rd),
    .rd_valid (rd_valid)
  );

  pfr_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (mac_clear),
    .in_valid (rd_valid),
    .x        (x_rd),
    .c        (c_rd),
    .busy     (mac_busy),
    .result   (mac_result)
  );

  `PFR_ASSERT_IMP(a_accept_idle, clk, rst, accept, state == ST_IDLE && !tgt_busy)
  `PFR_ASSERT_IMP(a_emit_drained, clk, rst, load_out, !mac_busy && !rd_valid)
  `PFR_ASSERT_NEXT(a_last_ends_item, clk, rst, load_out && last_next, state == ST_IDLE)
  `PFR_ASSERT_IMP(a_target_in_range, clk, rst, !tgt_busy && !tgt_start,
                  FACTOR_W'(tgt) < m_eff)

endmodule
